// ===== rtl/pde_pkg.sv =====
// pulse distance encoder package: field widths, register indexes and the
// configuration bundle shared by the register file and the top level
// no dependencies
package pde_pkg;

  localparam int HT_W       = 12;  // high and low mark lengths
  localparam int PX_W       = 15;  // 3*low + 2*high
  localparam int SYNC_W     = 16;  // 2*px
  localparam int GAP_W      = 18;  // 4*sync
  localparam int SEG_W      = 21;  // 50*sync, longest segment
  localparam int BC_W       = 6;
  localparam int RC_W       = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TIME    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TIME     = 2'd3;

  // settings plus segment lengths already worked out from them
  typedef struct packed {
    logic [BC_W-1:0]   bit_count;
    logic [RC_W-1:0]   repeat_count;
    logic [HT_W-1:0]   hi_len;
    logic [HT_W-1:0]   lo_len;
    logic [PX_W-1:0]   px_len;
    logic [SYNC_W-1:0] sync_len;
    logic [GAP_W-1:0]  gap_len;
    logic [SEG_W-1:0]  final_len;
  } pde_cfg_t;

endpackage

// ===== rtl/pde_cfg_regs.sv =====
// configuration registers of the pulse distance encoder, with the derived
// segment lengths registered at write time
// depends on pde_pkg
module pde_cfg_regs
  import pde_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output pde_cfg_t              cfg
);

  pde_cfg_t cfg_r;
  pde_cfg_t cfg_nxt;

  always_comb begin
    logic [HT_W-1:0]   hi_raw;
    logic [HT_W-1:0]   lo_raw;
    logic [HT_W-1:0]   hi_eff;
    logic [HT_W-1:0]   lo_eff;
    logic [PX_W-1:0]   px;
    logic [SYNC_W-1:0] sync_v;
    cfg_nxt = cfg_r;
    hi_raw  = cfg_r.hi_len;
    lo_raw  = cfg_r.lo_len;
    if (cfg_we) begin
      case (cfg_index)
        REG_BIT_COUNT:    cfg_nxt.bit_count    = cfg_wdata[BC_W-1:0];
        REG_REPEAT_COUNT: cfg_nxt.repeat_count = cfg_wdata[RC_W-1:0];
        REG_HIGH_TIME:    hi_raw               = cfg_wdata[HT_W-1:0];
        REG_LOW_TIME:     lo_raw               = cfg_wdata[HT_W-1:0];
        default: ;
      endcase
    end
    // a zero length counts as one tick
    hi_eff = (hi_raw == '0) ? HT_W'(1) : hi_raw;
    lo_eff = (lo_raw == '0) ? HT_W'(1) : lo_raw;
    px     = (PX_W'(lo_eff) << 1) + PX_W'(lo_eff) + (PX_W'(hi_eff) << 1);
    sync_v = {px, 1'b0};
    cfg_nxt.hi_len    = hi_eff;
    cfg_nxt.lo_len    = lo_eff;
    cfg_nxt.px_len    = px;
    cfg_nxt.sync_len  = sync_v;
    cfg_nxt.gap_len   = {sync_v, 2'b00};
    // 50*sync as 32 + 16 + 2
    cfg_nxt.final_len = (SEG_W'(sync_v) << 5) + (SEG_W'(sync_v) << 4) + (SEG_W'(sync_v) << 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bit_count    <= BC_W'(32);
      cfg_r.repeat_count <= RC_W'(4);
      cfg_r.hi_len       <= HT_W'(300);
      cfg_r.lo_len       <= HT_W'(300);
      cfg_r.px_len       <= PX_W'(1500);
      cfg_r.sync_len     <= SYNC_W'(3000);
      cfg_r.gap_len      <= GAP_W'(12000);
      cfg_r.final_len    <= SEG_W'(150000);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/pulse_distance_rf_encoder.sv =====
// pulse distance on-off keyed encoder, top level
// each accepted word's result word is registered in the output register
// throughput: one word per cycle; the segment counter and phase step once per tick word
// the output register frees itself when taken, so input is stalled only by a held result
// reset (rst_n low, synchronous): idle, no result word valid, counters clear, settings to defaults
module pulse_distance_rf_encoder
  import pde_pkg::*;
#(
  parameter int MESSAGE_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input words
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_command,
  input  logic [31:0]           in_message,
  // result words
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_pin_level,
  output logic                  out_busy_res,
  output logic                  out_done_res,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // width of the bits-left counter, which must hold MESSAGE_WIDTH itself
  localparam int BL_W  = $clog2(MESSAGE_WIDTH + 1);
  // width of a bit index into the message
  localparam int IDX_W = (MESSAGE_WIDTH > 1) ? $clog2(MESSAGE_WIDTH) : 1;
  // message port is 32 bits; widen it when the stored word is wider
  localparam int EXT_W = (MESSAGE_WIDTH > 32) ? MESSAGE_WIDTH : 32;

  // phase codes
  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_SYNC_HI = 4'd1;
  localparam logic [3:0] PH_SYNC_LO = 4'd2;
  localparam logic [3:0] PH_B_H1    = 4'd3;
  localparam logic [3:0] PH_B_L1    = 4'd4;
  localparam logic [3:0] PH_B_H2    = 4'd5;
  localparam logic [3:0] PH_B_L2    = 4'd6;
  localparam logic [3:0] PH_END_HI  = 4'd7;
  localparam logic [3:0] PH_END_LO  = 4'd8;
  localparam logic [3:0] PH_GAP     = 4'd9;
  localparam logic [3:0] PH_FINAL   = 4'd10;

  pde_cfg_t cfg;

  pde_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // transmitter state
  logic [3:0]               phase_r,       phase_nxt;
  logic [SEG_W-1:0]         seg_cnt_r,     seg_cnt_nxt;
  logic [MESSAGE_WIDTH-1:0] shift_r,       shift_nxt;
  logic [BL_W-1:0]          bits_left_r,   bits_left_nxt;
  logic [RC_W-1:0]          frames_left_r, frames_left_nxt;

  // output register
  logic out_valid_r;
  logic out_pin_level_r, out_pin_level_nxt;
  logic out_busy_res_r,  out_busy_res_nxt;
  logic out_done_res_r,  out_done_res_nxt;

  logic             in_fire;
  logic             active;
  logic             cur_bit;
  logic [BL_W-1:0]  bl_m1;
  logic [BL_W-1:0]  bl_after;
  logic [BL_W-1:0]  bc_clamp;
  logic [6:0]       bc_wide;
  logic [SEG_W-1:0] cnt_dec;
  logic             expire;
  logic [EXT_W-1:0] msg_ext;
  logic             frame_start;
  logic [RC_W-1:0]  frames_src;

  // the output register empties as it is taken, so a new word can enter alongside
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign active  = (phase_r != PH_IDLE);
  assign msg_ext = EXT_W'(in_message);

  // bit under transmission: bit (bits_left - 1) of the message, zero when none left
  assign bl_m1   = bits_left_r - BL_W'(1);
  assign cur_bit = (bits_left_r == '0) ? 1'b0 : shift_r[bl_m1[IDX_W-1:0]];
  assign bl_after = (bits_left_r == '0) ? '0 : bl_m1;

  // bit count clamped to the stored message width
  assign bc_wide  = {1'b0, cfg.bit_count};
  assign bc_clamp = (bc_wide > 7'(MESSAGE_WIDTH)) ? BL_W'(MESSAGE_WIDTH) : BL_W'(bc_wide);

  // segment countdown; the tick that empties it moves to the next segment
  assign cnt_dec = (seg_cnt_r == '0) ? '0 : seg_cnt_r - SEG_W'(1);
  assign expire  = (cnt_dec == '0);

  always_comb begin
    phase_nxt       = phase_r;
    seg_cnt_nxt     = seg_cnt_r;
    shift_nxt       = shift_r;
    bits_left_nxt   = bits_left_r;
    frames_left_nxt = frames_left_r;
    frame_start     = 1'b0;
    frames_src      = frames_left_r;
    out_done_res_nxt = 1'b0;

    if (in_fire) begin
      if (in_command) begin
        // start while busy is dropped and counts as no tick
        if (!active) begin
          shift_nxt   = msg_ext[MESSAGE_WIDTH-1:0];
          frame_start = 1'b1;
          frames_src  = cfg.repeat_count;
        end
      end else if (active) begin
        seg_cnt_nxt = cnt_dec;
        if (expire) begin
          case (phase_r)
            PH_SYNC_HI: begin
              phase_nxt   = PH_SYNC_LO;
              seg_cnt_nxt = SEG_W'(cfg.sync_len);
            end
            PH_SYNC_LO: begin
              phase_nxt   = (bits_left_r != '0) ? PH_B_H1 : PH_END_HI;
              seg_cnt_nxt = SEG_W'(cfg.hi_len);
            end
            PH_B_H1: begin
              // a one has the long space first
              phase_nxt   = PH_B_L1;
              seg_cnt_nxt = cur_bit ? SEG_W'(cfg.px_len) : SEG_W'(cfg.lo_len);
            end
            PH_B_L1: begin
              phase_nxt   = PH_B_H2;
              seg_cnt_nxt = SEG_W'(cfg.hi_len);
            end
            PH_B_H2: begin
              phase_nxt   = PH_B_L2;
              seg_cnt_nxt = cur_bit ? SEG_W'(cfg.lo_len) : SEG_W'(cfg.px_len);
            end
            PH_B_L2: begin
              bits_left_nxt = bl_after;
              phase_nxt     = (bl_after != '0) ? PH_B_H1 : PH_END_HI;
              seg_cnt_nxt   = SEG_W'(cfg.hi_len);
            end
            PH_END_HI: begin
              phase_nxt   = PH_END_LO;
              seg_cnt_nxt = SEG_W'(cfg.lo_len);
            end
            PH_END_LO: begin
              phase_nxt   = PH_GAP;
              seg_cnt_nxt = SEG_W'(cfg.gap_len);
            end
            PH_GAP: begin
              frame_start = 1'b1;
            end
            default: begin
              // end of the final gap
              phase_nxt        = PH_IDLE;
              out_done_res_nxt = 1'b1;
            end
          endcase
        end
      end
    end

    // frame start: another frame if any are left, else the closing low
    if (frame_start) begin
      if (frames_src == '0) begin
        frames_left_nxt = frames_src;
        phase_nxt       = PH_FINAL;
        seg_cnt_nxt     = cfg.final_len;
      end else begin
        frames_left_nxt = frames_src - RC_W'(1);
        bits_left_nxt   = bc_clamp;
        phase_nxt       = PH_SYNC_HI;
        seg_cnt_nxt     = SEG_W'(cfg.hi_len);
      end
    end

    out_pin_level_nxt = (phase_nxt == PH_SYNC_HI) || (phase_nxt == PH_B_H1) ||
                        (phase_nxt == PH_B_H2) || (phase_nxt == PH_END_HI);
    out_busy_res_nxt  = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      seg_cnt_r     <= '0;
      shift_r       <= '0;
      bits_left_r   <= '0;
      frames_left_r <= '0;
    end else begin
      phase_r       <= phase_nxt;
      seg_cnt_r     <= seg_cnt_nxt;
      shift_r       <= shift_nxt;
      bits_left_r   <= bits_left_nxt;
      frames_left_r <= frames_left_nxt;
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_pin_level_r <= out_pin_level_nxt;
      out_busy_res_r  <= out_busy_res_nxt;
      out_done_res_r  <= out_done_res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pin_level = out_pin_level_r;
  assign out_busy_res  = out_busy_res_r;
  assign out_done_res  = out_done_res_r;

`ifndef ASSERT_OFF
  // a running segment always has ticks left
  a_seg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) |-> (seg_cnt_r != '0))
    else $error("segment counter empty while transmitting");

  // never more bits pending than the message holds
  a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bits_left_r <= BL_W'(MESSAGE_WIDTH))
    else $error("bits left exceeds message width");

  // done only marks the word that leaves the busy state
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_done_res_r) |-> !out_busy_res_r)
    else $error("done reported while still busy");

  // the pin goes high only during a transmission
  a_pin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pin_level_r) |-> out_busy_res_r)
    else $error("pin high while idle");

  // a tick word with the counter at one leaves the current phase
  a_phase_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_command && (phase_r != PH_IDLE) && (seg_cnt_r == SEG_W'(1))
     && (phase_r != PH_GAP)) |=> (phase_r != $past(phase_r)))
    else $error("phase held after its segment ran out");
`endif

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for pulse_distance_rf_encoder: drives tick and start words,
// predicts pin level, busy and done per word, and checks every result word
// depends on pde_pkg (register indexes and field widths) and the encoder rtl
`timescale 1ns / 100ps

module testbench;
  import pde_pkg::*;

  localparam int WORD_TARGET = 1650;  // words sent before the widest-settings tail
  localparam int TAIL_CYCLES = 8;     // settle time once nothing is due
  localparam int MAX_WAIT    = 18;    // longest idle or stall per word

  // input word commands
  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_e;

  // segments of the pulse train, as the encoder walks them
  typedef enum logic [3:0] {
    SEG_IDLE,
    SEG_SYNC_MARK,
    SEG_SYNC_SPACE,
    SEG_BIT_MARK1,
    SEG_BIT_SPACE1,
    SEG_BIT_MARK2,
    SEG_BIT_SPACE2,
    SEG_TAIL_MARK,
    SEG_TAIL_SPACE,
    SEG_FRAME_GAP,
    SEG_FINAL_GAP
  } seg_e;

  typedef enum logic [1:0] {
    ROW_WORD,     // word checked against the predicted pin train
    ROW_CHECKED,  // word with its result typed into the table
    ROW_REG       // register write, only ever done with the encoder idle
  } row_kind_e;

  typedef struct packed {
    logic pin;
    logic busy;
    logic done;
  } pin_result_t;

  typedef struct packed {
    row_kind_e             kind;
    cmd_e                  cmd;
    logic [31:0]           msg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    pin_result_t           want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_command;
  logic [31:0]           in_message;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_pin_level;
  logic                  out_busy_res;
  logic                  out_done_res;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pulse_distance_rf_encoder u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_message    (in_message),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pin_level (out_pin_level),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // pin train predictor: settings as last written, plus the transmitter state
  // ---------------------------------------------------------------------------
  logic [BC_W-1:0]  set_bit_count = 6'd32;
  logic [RC_W-1:0]  set_repeats   = 8'd4;
  logic [HT_W-1:0]  set_high      = 12'd300;
  logic [HT_W-1:0]  set_low       = 12'd300;

  seg_e             seg;
  logic [SEG_W-1:0] ticks_left;
  logic [31:0]      shift_reg;
  logic [5:0]       bits_to_send;
  logic [7:0]       frames_to_send;
  logic             tx_active;

  pin_result_t      pin_results_due[$];  // one per accepted word, oldest first
  stim_row_t        directed_rows[$];
  int               words_counted = 0;   // words sent so far
  int               mismatches = 0;
  int               scenario = 0;
  bit               in_calm = 1'b0;
  bit               out_calm = 1'b0;

  // a zero length register counts as one tick
  function automatic int mark_len();
    return (set_high == 0) ? 1 : set_high;
  endfunction

  function automatic int space_len();
    return (set_low == 0) ? 1 : set_low;
  endfunction

  function automatic int pulse_len();
    return 3 * space_len() + 2 * mark_len();
  endfunction

  function automatic int sync_len();
    return 2 * pulse_len();
  endfunction

  // bit being sent, msb first out of the bits still to go
  function automatic logic next_bit();
    if (bits_to_send == 0) return 1'b0;
    return shift_reg[bits_to_send - 1];
  endfunction

  task automatic load_segment(input seg_e nxt);
    logic b;
    b = next_bit();
    seg = nxt;
    case (nxt)
      SEG_SYNC_MARK, SEG_BIT_MARK1, SEG_BIT_MARK2, SEG_TAIL_MARK:
        ticks_left = SEG_W'(mark_len());
      SEG_SYNC_SPACE: ticks_left = SEG_W'(sync_len());
      // a one has the long space first, a zero has it second
      SEG_BIT_SPACE1: ticks_left = b ? SEG_W'(pulse_len()) : SEG_W'(space_len());
      SEG_BIT_SPACE2: ticks_left = b ? SEG_W'(space_len()) : SEG_W'(pulse_len());
      SEG_TAIL_SPACE: ticks_left = SEG_W'(space_len());
      SEG_FRAME_GAP:  ticks_left = SEG_W'(4 * sync_len());
      SEG_FINAL_GAP:  ticks_left = SEG_W'(50 * sync_len());
      default:        ticks_left = '0;
    endcase
  endtask

  // the bit count is latched at each frame start; no frames left means the final gap
  task automatic start_frame();
    if (frames_to_send == 0) begin
      load_segment(SEG_FINAL_GAP);
    end else begin
      frames_to_send = frames_to_send - 8'd1;
      bits_to_send = (set_bit_count > 32) ? 6'd32 : set_bit_count;
      load_segment(SEG_SYNC_MARK);
    end
  endtask

  task automatic predict_pin_word(input cmd_e cmd, input logic [31:0] msg,
                                  output pin_result_t r);
    logic fin;
    fin = 1'b0;
    if (cmd == CMD_START) begin
      // a start while busy is dropped and does not count as a tick
      if (!tx_active) begin
        shift_reg = msg;
        frames_to_send = set_repeats;
        tx_active = 1'b1;
        start_frame();
      end
    end else if (tx_active) begin
      if (ticks_left != 0) ticks_left = ticks_left - SEG_W'(1);
      if (ticks_left == 0) begin
        case (seg)
          SEG_SYNC_MARK: load_segment(SEG_SYNC_SPACE);
          SEG_SYNC_SPACE, SEG_BIT_SPACE2: begin
            if (seg == SEG_BIT_SPACE2 && bits_to_send != 0) bits_to_send = bits_to_send - 6'd1;
            if (bits_to_send != 0) load_segment(SEG_BIT_MARK1);
            else load_segment(SEG_TAIL_MARK);
          end
          SEG_BIT_MARK1:  load_segment(SEG_BIT_SPACE1);
          SEG_BIT_SPACE1: load_segment(SEG_BIT_MARK2);
          SEG_BIT_MARK2:  load_segment(SEG_BIT_SPACE2);
          SEG_TAIL_MARK:  load_segment(SEG_TAIL_SPACE);
          SEG_TAIL_SPACE: load_segment(SEG_FRAME_GAP);
          SEG_FRAME_GAP:  start_frame();
          default: begin
            // end of the final gap
            seg = SEG_IDLE;
            tx_active = 1'b0;
            fin = 1'b1;
          end
        endcase
      end
    end
    r.pin = (seg == SEG_SYNC_MARK) || (seg == SEG_BIT_MARK1) ||
            (seg == SEG_BIT_MARK2) || (seg == SEG_TAIL_MARK);
    r.busy = tx_active;
    r.done = fin;
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // valid is held from the falling edge until a rising edge sees ready; it is
  // dropped at the next falling edge only if an idle gap follows
  task automatic send_word(input cmd_e cmd, input logic [31:0] msg, input logic typed,
                           input pin_result_t want);
    int          gap;
    pin_result_t pred;
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, MAX_WAIT);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_message <= msg;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    words_counted++;
    predict_pin_word(cmd, msg, pred);
    pin_results_due.push_back(typed ? want : pred);
  endtask

  // writes happen only with the encoder idle and every result word taken
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pin_results_due.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BIT_COUNT:    set_bit_count = data[BC_W-1:0];
      REG_REPEAT_COUNT: set_repeats   = data[RC_W-1:0];
      REG_HIGH_TIME:    set_high      = data[HT_W-1:0];
      REG_LOW_TIME:     set_low       = data[HT_W-1:0];
      default: ;
    endcase
  endtask

  // mostly ticks, with the odd start that a busy encoder must drop
  task automatic send_tick_or_stray_start();
    if ($urandom_range(0, 24) == 0) send_word(CMD_START, $urandom, 1'b0, '0);
    else send_word(CMD_TICK, $urandom, 1'b0, '0);
  endtask

  // short lengths keep a whole transmission, final gap included, affordable
  function automatic logic [CFG_DATA_W-1:0] pick_len();
    return ($urandom_range(0, 4) == 0) ? 12'd2 : 12'($urandom_range(0, 1));
  endfunction

  // one full transmission under fresh settings, or the rest of one under way
  task automatic run_transmission();
    logic [CFG_DATA_W-1:0] bc_data;
    logic [CFG_DATA_W-1:0] rc_data;
    if (!tx_active) begin
      // upper write bits are junk that the register must drop
      bc_data = 12'($urandom_range(0, 4095));
      rc_data = 12'($urandom_range(0, 4095));
      case (scenario % 4)
        2: begin  // a few bits, one or two frames
          bc_data[5:0] = 6'($urandom_range(1, 6));
          rc_data[7:0] = 8'($urandom_range(1, 2));
        end
        0: begin  // bit count above the message width, clamped to 32
          bc_data[5:0] = 6'($urandom_range(33, 63));
          rc_data[7:0] = 8'd1;
        end
        1: begin  // no bits: sync and closing mark only, several frames
          bc_data[5:0] = 6'd0;
          rc_data[7:0] = 8'($urandom_range(2, 3));
        end
        default: begin  // no frames at all, only the final gap
          bc_data[5:0] = 6'($urandom_range(0, 63));
          rc_data[7:0] = 8'd0;
        end
      endcase
      scenario++;
      set_reg(REG_BIT_COUNT, bc_data);
      set_reg(REG_REPEAT_COUNT, rc_data);
      set_reg(REG_HIGH_TIME, (scenario == 1) ? 12'($urandom_range(0, 1)) : pick_len());
      set_reg(REG_LOW_TIME, (scenario == 1) ? 12'($urandom_range(0, 1)) : pick_len());
      send_word(CMD_START, $urandom, 1'b0, '0);
    end
    while (tx_active) send_tick_or_stray_start();
    // a few ticks with nothing to send
    repeat ($urandom_range(0, 3)) send_word(CMD_TICK, $urandom, 1'b0, '0);
  endtask

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx  = idx;
    r.data = data;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_word(input cmd_e cmd, input logic [31:0] msg);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.cmd  = cmd;
    r.msg  = msg;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_checked(input cmd_e cmd, input logic [31:0] msg,
                                      input logic pin, input logic busy, input logic done);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CHECKED;
    r.cmd  = cmd;
    r.msg  = msg;
    r.want = '{pin: pin, busy: busy, done: done};
    directed_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus: reset, directed table, random transmissions, extreme settings
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_command = CMD_TICK;
    in_message = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;

    seg            = SEG_IDLE;
    ticks_left     = '0;
    shift_reg      = '0;
    bits_to_send   = '0;
    frames_to_send = '0;
    tx_active      = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // idle after reset: ticks change nothing and the message is ignored
    add_checked(CMD_TICK, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
    add_checked(CMD_TICK, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
    // no frames and zero lengths, which count as one tick each
    add_reg(REG_BIT_COUNT, 12'd5);
    add_reg(REG_REPEAT_COUNT, 12'd0);
    add_reg(REG_HIGH_TIME, 12'd0);
    add_reg(REG_LOW_TIME, 12'd0);
    // start goes straight into the final gap, pin low but busy
    add_checked(CMD_START, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
    // start while busy is dropped
    add_checked(CMD_START, 32'h0000_0000, 1'b0, 1'b1, 1'b0);
    add_checked(CMD_TICK, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0);
    for (int i = 0; i < 12; i++) add_word(CMD_TICK, i[0] ? 32'hAAAA_AAAA : 32'h5555_5555);

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_REG:     set_reg(directed_rows[i].idx, directed_rows[i].data);
        ROW_CHECKED: send_word(directed_rows[i].cmd, directed_rows[i].msg, 1'b1,
                               directed_rows[i].want);
        default:     send_word(directed_rows[i].cmd, directed_rows[i].msg, 1'b0, '0);
      endcase
    end

    // the first pass finishes the directed transmission, then the clamped
    // bit count and the bitless frames each get at least one whole transmission
    while (words_counted < WORD_TARGET || scenario < 2) run_transmission();

    // widest settings; far too long to finish, so only the opening is watched
    set_reg(REG_BIT_COUNT, {6'($urandom_range(0, 63)), 6'd32});
    set_reg(REG_REPEAT_COUNT, 12'h0FF);
    set_reg(REG_HIGH_TIME, 12'hFFF);
    set_reg(REG_LOW_TIME, 12'hFFF);
    send_word(CMD_START, $urandom, 1'b0, '0);
    repeat (300) send_tick_or_stray_start();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pin_results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random stalls on ready, every result word checked in order
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int          stall;
    pin_result_t want;
    out_ready = 1'b0;
    forever begin
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      stall = out_calm ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      if (pin_results_due.size() == 0) begin
        $display("%0t: result word with none due, pin %b busy %b done %b", $time,
                 out_pin_level, out_busy_res, out_done_res);
        mismatches++;
      end else begin
        want = pin_results_due.pop_front();
        if (out_pin_level !== want.pin) begin
          $display("%0t: pin_level expected %b, got %b", $time, want.pin, out_pin_level);
          mismatches++;
        end
        if (out_busy_res !== want.busy) begin
          $display("%0t: busy_res expected %b, got %b", $time, want.busy, out_busy_res);
          mismatches++;
        end
        if (out_done_res !== want.done) begin
          $display("%0t: done_res expected %b, got %b", $time, want.done, out_done_res);
          mismatches++;
        end
      end
    end
  end

  // hung handshake guard, several times the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
